// ===== design/cbt_pkg.sv =====
// Shared types and constants for the cubic Bezier tessellator.
// No dependencies; imported by every module of the block.
package cbt_pkg;
  localparam int U_BITS    = 17;   // Q1.16 parameter, 0 .. 65536
  localparam int CNT_BITS  = 6;    // sample count and index width
  localparam int CFG_BITS  = 60;   // control point register width
  localparam int NUM_CP    = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_CP0 = 2'd0;
  localparam logic [1:0] CFG_CP1 = 2'd1;
  localparam logic [1:0] CFG_CP2 = 2'd2;
  localparam logic [1:0] CFG_CP3 = 2'd3;

  // one queued request: clamped sample count
  typedef struct packed {
    logic [CNT_BITS-1:0] segs;   // s+1, number of segments
  } req_t;
endpackage

// ===== design/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator top level: configuration registers,
// request front end and evaluation back end. Depends on cbt_pkg.
//
// Usage: write the four control points (x low, then y, then z, each a
// signed Q8.12 field) on the cfg channel while idle. Each request on the
// in channel carries an interior sample count s (clamped so s+2 fits
// MAX_POINTS_OUT) and yields s+2 points on the out channel at
// u = floor(i*65536/(s+1)), the last one marked with last_point.
// For each point, u comes from restoring division; the control points are
// then loaded and 18 lerps run on one shared multiplier before the point
// goes out. The front queue holds two requests, so new requests are taken
// while a curve is being evaluated.
// A stalled result holds in the output register and the sequencer
// waits on it. Reset clears the control points to zero, empties the
// queue and drops any result in flight.
module cubic_bezier_tessellator #(
  parameter int MAX_POINTS_OUT = 64,
  parameter int COORD_WIDTH    = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [cbt_pkg::CFG_BITS-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cbt_pkg::CNT_BITS-1:0]  in_extra_samples,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic signed [COORD_WIDTH-1:0] out_point_z,
  output logic [cbt_pkg::CNT_BITS-1:0]  out_sample_index,
  output logic                          out_last_point
);
  import cbt_pkg::*;

  logic [CFG_BITS-1:0] cp0_r, cp1_r, cp2_r, cp3_r;
  logic                q_valid, q_pop;
  req_t                q_data;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp0_r <= '0;
      cp1_r <= '0;
      cp2_r <= '0;
      cp3_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CP0: cp0_r <= cfg_data;
        CFG_CP1: cp1_r <= cfg_data;
        CFG_CP2: cp2_r <= cfg_data;
        CFG_CP3: cp3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  cbt_front #(.MAX_POINTS_OUT(MAX_POINTS_OUT)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_extra_samples,
    .q_valid, .q_pop, .q_data
  );

  cbt_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst_n, .cp0(cp0_r), .cp1(cp1_r), .cp2(cp2_r), .cp3(cp3_r),
    .q_valid, .q_pop, .q_data, .out_valid, .out_stall,
    .out_point_x, .out_point_y, .out_point_z, .out_sample_index, .out_last_point
  );
endmodule

// ===== design/cbt_front.sv =====
// Front end: accepts requests, clamps the sample count and queues it.
// Depends on cbt_pkg.
module cbt_front #(
  parameter int MAX_POINTS_OUT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cbt_pkg::CNT_BITS-1:0]  in_extra_samples,
  output logic                          q_valid,
  input  logic                          q_pop,
  output cbt_pkg::req_t                 q_data
);
  import cbt_pkg::*;

  localparam logic [CNT_BITS:0] MaxS = (CNT_BITS+1)'(MAX_POINTS_OUT - 2);

  req_t             mem_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [CNT_BITS:0] s_cl;
  logic             push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  // clamp s, then store s+1
  always_comb begin
    s_cl = {1'b0, in_extra_samples};
    if (s_cl > MaxS) s_cl = MaxS;
  end

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r].segs <= CNT_BITS'(s_cl + 1'b1);
  end
endmodule

// ===== design/cbt_back.sv =====
// Back end: sequencer computing u by restoring division and three levels of
// de Casteljau lerps on one shared multiplier. Depends on cbt_pkg.
module cbt_back #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cbt_pkg::CFG_BITS-1:0]  cp0,
  input  logic [cbt_pkg::CFG_BITS-1:0]  cp1,
  input  logic [cbt_pkg::CFG_BITS-1:0]  cp2,
  input  logic [cbt_pkg::CFG_BITS-1:0]  cp3,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  cbt_pkg::req_t                 q_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_point_x,
  output logic signed [COORD_WIDTH-1:0] out_point_y,
  output logic signed [COORD_WIDTH-1:0] out_point_z,
  output logic [cbt_pkg::CNT_BITS-1:0]  out_sample_index,
  output logic                          out_last_point
);
  import cbt_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;            // difference width
  localparam int PW = DW + U_BITS + 1;   // product width
  localparam int NB = CNT_BITS + 16 + 1; // dividend width
  localparam int DIV_STEPS = NB;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]            st_r, st_nxt;
  logic [CNT_BITS-1:0]   segs_r, idx_r;
  logic [NB-1:0]         quo_r;        // dividend shifting into quotient
  logic [CNT_BITS:0]     rem_r;
  logic [4:0]            dstep_r;
  logic [U_BITS-1:0]     u_r;
  logic signed [CW-1:0]  p_r [3][4];
  logic [1:0]            axis_r, j_r, lvl_r;  // lvl_r counts k = 3..1
  logic signed [PW-1:0]  prod_r;
  logic signed [CW-1:0]  a_s, b_s;
  logic signed [DW-1:0]  diff;
  logic signed [PW-1:0]  prod_c, q_c;
  logic [CNT_BITS:0]     rem_sh;
  logic signed [CW-1:0]  res_x_r, res_y_r, res_z_r;
  logic [CNT_BITS-1:0]   oidx_r;
  logic                  olast_r, ovalid_r;

  function automatic logic [CFG_BITS-1:0] cp_sel(input int k);
    case (k)
      0: cp_sel = cp0;
      1: cp_sel = cp1;
      2: cp_sel = cp2;
      default: cp_sel = cp3;
    endcase
  endfunction

  assign out_valid        = ovalid_r;
  assign out_point_x      = res_x_r;
  assign out_point_y      = res_y_r;
  assign out_point_z      = res_z_r;
  assign out_sample_index = oidx_r;
  assign out_last_point   = olast_r;
  assign q_pop            = (st_r == S_IDLE) && q_valid;

  // shared lerp datapath
  assign a_s    = p_r[axis_r][j_r];
  assign b_s    = p_r[axis_r][j_r + 2'd1];
  assign diff   = DW'(b_s) - DW'(a_s);
  assign prod_c = PW'(diff) * $signed({1'b0, u_r});
  // floor division by 65536 is an arithmetic shift
  assign q_c    = prod_r >>> 16;
  assign rem_sh = {rem_r[CNT_BITS-1:0], quo_r[NB-1]};

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_DIV;
      S_DIV:  if (dstep_r == 5'(DIV_STEPS - 1)) st_nxt = S_LOAD;
      S_LOAD: st_nxt = S_MUL;
      S_MUL:  st_nxt = S_ADD;
      S_ADD:  if (axis_r == 2'd2 && j_r == lvl_r - 2'd1 && lvl_r == 2'd1)
                st_nxt = S_OUT;
              else st_nxt = S_MUL;
      S_OUT:  if (!ovalid_r || !out_stall)
                st_nxt = (idx_r == segs_r) ? S_IDLE : S_DIV;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_OUT && (!ovalid_r || !out_stall)) ovalid_r <= 1'b1;
      else if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        segs_r <= q_data.segs;
        idx_r  <= '0;
        quo_r  <= '0;
        rem_r  <= '0;
        dstep_r <= '0;
      end
      S_DIV: begin
        // restoring division of i*65536 by s+1, one bit a cycle
        dstep_r <= dstep_r + 5'd1;
        if (rem_sh >= {1'b0, segs_r}) begin
          rem_r <= rem_sh - {1'b0, segs_r};
          quo_r <= {quo_r[NB-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NB-2:0], 1'b0};
        end
      end
      S_LOAD: begin
        u_r <= quo_r[U_BITS-1:0];
        for (int k = 0; k < 4; k++) begin
          p_r[0][k] <= CW'(cp_sel(k) >> 0);
          p_r[1][k] <= CW'(cp_sel(k) >> CW);
          p_r[2][k] <= CW'(cp_sel(k) >> (2*CW));
        end
        axis_r <= 2'd0;
        j_r    <= 2'd0;
        lvl_r  <= 2'd3;
      end
      S_MUL: prod_r <= prod_c;
      S_ADD: begin
        p_r[axis_r][j_r] <= a_s + CW'(q_c);
        if (axis_r == 2'd2) begin
          axis_r <= 2'd0;
          if (j_r == lvl_r - 2'd1) begin
            j_r   <= 2'd0;
            lvl_r <= lvl_r - 2'd1;
          end else j_r <= j_r + 2'd1;
        end else axis_r <= axis_r + 2'd1;
      end
      S_OUT: if (!ovalid_r || !out_stall) begin
        res_x_r <= p_r[0][0];
        res_y_r <= p_r[1][0];
        res_z_r <= p_r[2][0];
        oidx_r  <= idx_r;
        olast_r <= (idx_r == segs_r);
        idx_r   <= idx_r + 1'b1;
        dstep_r <= '0;
        rem_r   <= '0;
        quo_r   <= {1'b0, idx_r + 1'b1, 16'd0};
      end
      default: ;
    endcase
  end
endmodule

// ===== sim/cubic_bezier_tessellator_tb.sv =====
// Self-checking testbench for the cubic Bezier tessellator.
// Predicts curve points by fixed-point de Casteljau, origin rows as zero, and compares each output transfer.
// Depends on cbt_pkg and cubic_bezier_tessellator.
`timescale 1ns / 1ps

module cubic_bezier_tessellator_tb;
  import cbt_pkg::*;

  localparam int CW = 20;
  localparam int MAX_PTS = 64;
  localparam longint CYCLE_LIMIT = 5000000;
  localparam int RANDOM_ITEMS = 200;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic [5:0]    idx;
    logic          last;
  } curve_pt_t;

  // directed row: sample count, control point setting, typed-in origin check
  typedef struct {
    logic [5:0] s;
    int         setting;
    bit         origin;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_CP0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CNT_BITS-1:0] in_extra_samples = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] out_point_x, out_point_y, out_point_z;
  logic [CNT_BITS-1:0] out_sample_index;
  logic out_last_point;

  logic [CFG_BITS-1:0] ctrl_pts [NUM_CP];
  curve_pt_t pending_pts [$];
  int mismatches = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_off = 1'b0;
  int cur_setting = 0;

  dir_row_t dir_rows [17] = '{
    '{6'd0, 0, 1'b1}, '{6'd1, 0, 1'b1}, '{6'd62, 0, 1'b1}, '{6'd63, 0, 1'b1},
    '{6'd0, 1, 1'b0}, '{6'd1, 1, 1'b0}, '{6'd2, 1, 1'b0}, '{6'd63, 1, 1'b0},
    '{6'd31, 1, 1'b0}, '{6'd32, 1, 1'b0}, '{6'd0, 2, 1'b0}, '{6'd7, 2, 1'b0},
    '{6'd0, 3, 1'b0}, '{6'd3, 3, 1'b0}, '{6'd62, 3, 1'b0}, '{6'd16, 3, 1'b0},
    '{6'd5, 3, 1'b0}
  };

  cubic_bezier_tessellator u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_extra_samples(in_extra_samples),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_point_x(out_point_x), .out_point_y(out_point_y), .out_point_z(out_point_z),
    .out_sample_index(out_sample_index), .out_last_point(out_last_point)
  );

  always #6 clk = ~clk;

  // sign-extend the low coordinate field, dropping any carry above it
  function automatic longint wrap_coord(longint v);
    return {{(64-CW){v[CW-1]}}, v[CW-1:0]};
  endfunction

  // three levels of interpolation on one axis at parameter u (Q1.16)
  function automatic logic [CW-1:0] casteljau_axis(int axis, longint u);
    longint p [4];
    for (int k = 0; k < 4; k++) p[k] = wrap_coord(longint'(ctrl_pts[k][axis*CW +: CW]));
    for (int k = 3; k > 0; k--)
      for (int j = 0; j < k; j++)
        p[j] = wrap_coord(p[j] + (((p[j+1] - p[j]) * u) >>> 16));
    return p[0][CW-1:0];
  endfunction

  // queue every point of one curve request
  function automatic void predict_curve(logic [5:0] s_raw, bit origin);
    int s;
    int n;
    longint u;
    curve_pt_t pt;
    s = (s_raw + 2 > MAX_PTS) ? MAX_PTS - 2 : s_raw;
    n = s + 2;
    for (int i = 0; i < n; i++) begin
      u = (longint'(i) * 65536) / (s + 1);
      if (origin) begin
        pt.x = '0;
        pt.y = '0;
        pt.z = '0;
      end else begin
        pt.x = casteljau_axis(0, u);
        pt.y = casteljau_axis(1, u);
        pt.z = casteljau_axis(2, u);
      end
      pt.idx = i[5:0];
      pt.last = (i == n - 1);
      pending_pts = {pending_pts, pt};
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    ctrl_pts[idx] = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drain results, let the block settle, then load a control point set
  task automatic apply_setting(int setting);
    logic [CFG_BITS-1:0] v [NUM_CP];
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    case (setting)
      1: begin
        // opposite extremes per axis to force wrapping
        v[0] = {20'h7FFFF, 20'h80000, 20'h7FFFF};
        v[1] = {20'h80000, 20'h7FFFF, 20'h80000};
        v[2] = {20'h7FFFF, 20'h7FFFF, 20'h80000};
        v[3] = {20'h80000, 20'h80000, 20'h7FFFF};
      end
      2: for (int k = 0; k < NUM_CP; k++) v[k] = '1;
      default: for (int k = 0; k < NUM_CP; k++) v[k] = CFG_BITS'({$urandom, $urandom});
    endcase
    write_reg(CFG_CP0, v[0]);
    write_reg(CFG_CP1, v[1]);
    write_reg(CFG_CP2, v[2]);
    write_reg(CFG_CP3, v[3]);
    cur_setting = setting;
  endtask

  // offer one request and hold it until taken
  task automatic send_request(logic [5:0] s, bit origin);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_extra_samples = s;
    do @(posedge clk); while (in_stall);
    predict_curve(s, origin);
  endtask

  // receiver: random stall plus an optional long hold-off
  always @(negedge clk) out_stall <= hold_off || (!quiet && $urandom_range(0, 99) < 8);

  initial begin
    wait (hold_req);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (3000) @(negedge clk);
    hold_off = 1'b0;
  end

  // compare each output transfer with the oldest pending point
  always @(posedge clk) begin
    curve_pt_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point idx %0d", out_sample_index);
      end else begin
        want = pending_pts.pop_front();
        if (want.x !== out_point_x || want.y !== out_point_y || want.z !== out_point_z ||
            want.idx !== out_sample_index || want.last !== out_last_point) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h z=%h i=%0d l=%b got x=%h y=%h z=%h i=%0d l=%b",
                     want.x, want.y, want.z, want.idx, want.last, out_point_x,
                     out_point_y, out_point_z, out_sample_index, out_last_point);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [5:0] s;
    for (int k = 0; k < NUM_CP; k++) ctrl_pts[k] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].setting != cur_setting) apply_setting(dir_rows[r].setting);
      send_request(dir_rows[r].s, dir_rows[r].origin);
    end

    // random phases: new curve each phase, mostly short runs
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      in_valid = 1'b0;
      apply_setting(ph == 3 ? 1 : 3);
      quiet = (ph == 1);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        s = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 6)) : 6'($urandom_range(0, 63));
        send_request(s, 1'b0);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    quiet = 1'b0;

    while (pending_pts.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_pts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cbt_pkg.sv
design/cbt_front.sv
design/cbt_back.sv
design/cubic_bezier_tessellator.sv
sim/cubic_bezier_tessellator_tb.sv
